FILE: rtl/scbd_pkg.sv
// ---------------------------------------------------------------------------
// scbd_pkg
// shared types and constants of the sync / checksum / block deframer
// ---------------------------------------------------------------------------
`default_nettype none

package scbd_pkg;

  // reset values of the configuration registers
  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAF;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hC1;
  localparam logic [5:0] BLOCK_BYTES_RST = 6'd14;

  // legal range of the block size
  localparam logic [5:0] BLOCK_BYTES_MIN = 6'd6;
  localparam logic [5:0] BLOCK_BYTES_MAX = 6'd32;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_BLOCK_BYTES = 2'd2
  } reg_index_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_INVALID   = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  // parser phases, one-hot
  typedef enum logic [7:0] {
    PH_HUNT1 = 8'b0000_0001,
    PH_HUNT2 = 8'b0000_0010,
    PH_TYPE  = 8'b0000_0100,
    PH_LEN   = 8'b0000_1000,
    PH_CKLO  = 8'b0001_0000,
    PH_CKHI  = 8'b0010_0000,
    PH_DATA  = 8'b0100_0000,
    PH_DONE  = 8'b1000_0000
  } phase_t;

  // one result item
  typedef struct packed {
    logic [7:0]  payload_length;
    logic [15:0] first_y;
    logic [15:0] first_x;
    logic [5:0]  block_count;
    status_t     status;
  } result_t;

  // occupancy of the output stage
  typedef struct packed {
    logic out_full;
    logic skid_full;
  } skid_stat_t;

endpackage

`default_nettype wire

FILE: rtl/scbd_out_skid.sv
// ---------------------------------------------------------------------------
// scbd_out_skid
// output register with one skid entry for the result channel
// ---------------------------------------------------------------------------
`default_nettype none

module scbd_out_skid (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push_valid,
  input  scbd_pkg::result_t      push_data,
  output logic                   push_ready,
  output logic                   pop_valid,
  output scbd_pkg::result_t      pop_data,
  input  wire                    pop_ready,
  output scbd_pkg::skid_stat_t   stat
);

  logic              out_valid_r;
  scbd_pkg::result_t out_data_r;
  logic              skid_valid_r;
  scbd_pkg::result_t skid_data_r;
  logic              out_load;

  // output register may take new data when empty or being drained
  assign out_load = !out_valid_r || pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push_valid;
      end else begin
        out_valid_r  <= push_valid;
      end
    end else if (push_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
        if (push_valid) begin
          skid_data_r <= push_data;
        end
      end else if (push_valid) begin
        out_data_r <= push_data;
      end
    end else if (push_valid) begin
      skid_data_r <= push_data;
    end
  end

  assign push_ready     = !skid_valid_r;
  assign pop_valid      = out_valid_r;
  assign pop_data       = out_data_r;
  assign stat.out_full  = out_valid_r;
  assign stat.skid_full = skid_valid_r;

endmodule

`default_nettype wire

FILE: rtl/sync_checksum_block_deframer_top.sv
// ---------------------------------------------------------------------------
// sync_checksum_block_deframer_top
// sync / length / checksum packet deframer with block counting
// ---------------------------------------------------------------------------
// Takes one received byte per transfer and hunts for the two-byte sync pair,
// skips the type byte, captures the length byte and a little-endian 16-bit
// checksum, then sums the payload bytes (wrapping 16 bits), counts complete
// blocks of block_bytes bytes and keeps the X and Y words of the first block.
// One result is produced when the payload completes (valid or invalid), when
// the length is zero (invalid, on the second checksum byte), or when the
// window ends inside a packet (truncated). Later packets in the same window
// are ignored; in_tlast returns the parser to hunting. The parser state is
// updated in the cycle the byte is transferred and the result lands in a
// registered output stage with one skid entry, so a byte can be taken every
// cycle and in_tready drops only while the skid entry is occupied by a result
// the sink has not taken.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_checksum_block_deframer_top (
  input  wire         clk,
  input  wire         rst_n,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire         in_tlast,   // window_end
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata,  // [5:0] block_count, [21:6] first_x,
                                  // [37:22] first_y, [45:38] payload_length,
                                  // [47:46] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);

  // configuration registers
  logic [7:0] sync_first_r;
  logic [7:0] sync_second_r;
  logic [5:0] block_bytes_r;

  // parser state
  scbd_pkg::phase_t phase_r,           phase_nxt;
  logic [7:0]       declared_length_r, declared_length_nxt;
  logic [15:0]      expected_sum_r,    expected_sum_nxt;
  logic [15:0]      running_sum_r,     running_sum_nxt;
  logic [7:0]       bytes_seen_r,      bytes_seen_nxt;
  logic [4:0]       byte_in_block_r,   byte_in_block_nxt;
  logic [5:0]       blocks_done_r,     blocks_done_nxt;
  logic [15:0]      x_word_r,          x_word_nxt;
  logic [15:0]      y_word_r,          y_word_nxt;

  logic                 in_xfer;
  logic                 skid_ready;
  logic [5:0]           bb_eff;
  logic                 emit_valid;
  scbd_pkg::result_t    emit;
  scbd_pkg::result_t    pop_data;
  scbd_pkg::skid_stat_t skid_stat;

  assign in_tready = skid_ready;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // block size clamped into its legal range
  assign bb_eff = (block_bytes_r < scbd_pkg::BLOCK_BYTES_MIN) ? scbd_pkg::BLOCK_BYTES_MIN :
                  (block_bytes_r > scbd_pkg::BLOCK_BYTES_MAX) ? scbd_pkg::BLOCK_BYTES_MAX :
                  block_bytes_r;

  // configuration register file, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= scbd_pkg::SYNC_FIRST_RST;
      sync_second_r <= scbd_pkg::SYNC_SECOND_RST;
      block_bytes_r <= scbd_pkg::BLOCK_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        scbd_pkg::REG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        scbd_pkg::REG_SYNC_SECOND: sync_second_r <= cfg_data;
        scbd_pkg::REG_BLOCK_BYTES: block_bytes_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // next-state and result logic for one byte
  always_comb begin
    logic [5:0] pos_inc;
    logic [7:0] bytes_inc;
    logic       in_packet;

    phase_nxt           = phase_r;
    declared_length_nxt = declared_length_r;
    expected_sum_nxt    = expected_sum_r;
    running_sum_nxt     = running_sum_r;
    bytes_seen_nxt      = bytes_seen_r;
    byte_in_block_nxt   = byte_in_block_r;
    blocks_done_nxt     = blocks_done_r;
    x_word_nxt          = x_word_r;
    y_word_nxt          = y_word_r;
    emit_valid          = 1'b0;
    emit                = '0;
    pos_inc             = {1'b0, byte_in_block_r} + 6'd1;
    bytes_inc           = bytes_seen_r + 8'd1;

    unique case (phase_r)
      scbd_pkg::PH_HUNT1: begin
        if (in_tdata == sync_first_r) begin
          phase_nxt = scbd_pkg::PH_HUNT2;
        end
      end
      scbd_pkg::PH_HUNT2: begin
        // a repeated first sync byte keeps waiting for the second one
        if (in_tdata == sync_second_r) begin
          phase_nxt           = scbd_pkg::PH_TYPE;
          declared_length_nxt = '0;
          expected_sum_nxt    = '0;
          running_sum_nxt     = '0;
          bytes_seen_nxt      = '0;
          byte_in_block_nxt   = '0;
          blocks_done_nxt     = '0;
          x_word_nxt          = '0;
          y_word_nxt          = '0;
        end else if (in_tdata != sync_first_r) begin
          phase_nxt = scbd_pkg::PH_HUNT1;
        end
      end
      scbd_pkg::PH_TYPE: begin
        phase_nxt = scbd_pkg::PH_LEN;
      end
      scbd_pkg::PH_LEN: begin
        declared_length_nxt = in_tdata;
        phase_nxt           = scbd_pkg::PH_CKLO;
      end
      scbd_pkg::PH_CKLO: begin
        expected_sum_nxt = {8'h00, in_tdata};
        phase_nxt        = scbd_pkg::PH_CKHI;
      end
      scbd_pkg::PH_CKHI: begin
        expected_sum_nxt = {in_tdata, expected_sum_r[7:0]};
        if (declared_length_r == 8'd0) begin
          // empty packet is reported as invalid with everything zero
          emit_valid  = 1'b1;
          emit.status = scbd_pkg::ST_INVALID;
          phase_nxt   = scbd_pkg::PH_DONE;
        end else begin
          phase_nxt = scbd_pkg::PH_DATA;
        end
      end
      scbd_pkg::PH_DATA: begin
        running_sum_nxt = running_sum_r + {8'h00, in_tdata};
        if (blocks_done_r == 6'd0) begin
          if (byte_in_block_r == 5'd2) begin
            x_word_nxt = {x_word_r[15:8], in_tdata};
          end else if (byte_in_block_r == 5'd3) begin
            x_word_nxt = {in_tdata, x_word_r[7:0]};
          end else if (byte_in_block_r == 5'd4) begin
            y_word_nxt = {y_word_r[15:8], in_tdata};
          end else if (byte_in_block_r == 5'd5) begin
            y_word_nxt = {in_tdata, y_word_r[7:0]};
          end
        end
        if (pos_inc >= bb_eff) begin
          byte_in_block_nxt = '0;
          blocks_done_nxt   = blocks_done_r + 6'd1;
        end else begin
          byte_in_block_nxt = pos_inc[4:0];
        end
        bytes_seen_nxt = bytes_inc;
        if (bytes_inc == declared_length_r) begin
          emit_valid          = 1'b1;
          emit.status         = (running_sum_nxt == expected_sum_r) ?
                                scbd_pkg::ST_VALID : scbd_pkg::ST_INVALID;
          emit.payload_length = declared_length_r;
          if (running_sum_nxt == expected_sum_r) begin
            emit.block_count = blocks_done_nxt;
            if (blocks_done_nxt != 6'd0) begin
              emit.first_x = x_word_nxt;
              emit.first_y = y_word_nxt;
            end
          end
          phase_nxt = scbd_pkg::PH_DONE;
        end
      end
      scbd_pkg::PH_DONE: begin
        // later packets in the window are ignored
      end
      default: begin
        phase_nxt = scbd_pkg::PH_HUNT1;
      end
    endcase

    // window end: report a packet cut short, then clear for the next window
    in_packet = (phase_nxt == scbd_pkg::PH_TYPE) || (phase_nxt == scbd_pkg::PH_LEN) ||
                (phase_nxt == scbd_pkg::PH_CKLO) || (phase_nxt == scbd_pkg::PH_CKHI) ||
                (phase_nxt == scbd_pkg::PH_DATA);
    if (in_tlast) begin
      if (!emit_valid && in_packet) begin
        emit_valid  = 1'b1;
        emit        = '0;
        emit.status = scbd_pkg::ST_TRUNCATED;
        // length is known only once the length byte has been taken
        if ((phase_nxt == scbd_pkg::PH_CKLO) || (phase_nxt == scbd_pkg::PH_CKHI) ||
            (phase_nxt == scbd_pkg::PH_DATA)) begin
          emit.payload_length = declared_length_nxt;
        end
      end
      phase_nxt           = scbd_pkg::PH_HUNT1;
      declared_length_nxt = '0;
      expected_sum_nxt    = '0;
      running_sum_nxt     = '0;
      bytes_seen_nxt      = '0;
      byte_in_block_nxt   = '0;
      blocks_done_nxt     = '0;
      x_word_nxt          = '0;
      y_word_nxt          = '0;
    end
  end

  // parser state registers, advanced once per input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= scbd_pkg::PH_HUNT1;
      declared_length_r <= '0;
      expected_sum_r    <= '0;
      running_sum_r     <= '0;
      bytes_seen_r      <= '0;
      byte_in_block_r   <= '0;
      blocks_done_r     <= '0;
      x_word_r          <= '0;
      y_word_r          <= '0;
    end else if (in_xfer) begin
      phase_r           <= phase_nxt;
      declared_length_r <= declared_length_nxt;
      expected_sum_r    <= expected_sum_nxt;
      running_sum_r     <= running_sum_nxt;
      bytes_seen_r      <= bytes_seen_nxt;
      byte_in_block_r   <= byte_in_block_nxt;
      blocks_done_r     <= blocks_done_nxt;
      x_word_r          <= x_word_nxt;
      y_word_r          <= y_word_nxt;
    end
  end

  // registered result stage, decouples the sink from the byte stream
  scbd_out_skid u_out_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_xfer && emit_valid),
    .push_data  (emit),
    .push_ready (skid_ready),
    .pop_valid  (out_tvalid),
    .pop_data   (pop_data),
    .pop_ready  (out_tready),
    .stat       (skid_stat)
  );

  assign out_tuser = pop_data.status;
  assign out_tdata = {2'b00, pop_data.payload_length, pop_data.first_y,
                      pop_data.first_x, pop_data.block_count};

  // skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_stat.skid_full |-> skid_stat.out_full)
    else $error("skid entry holds data while output register is empty");

  // a valid result can only come out of the payload phase
  a_valid_from_data: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_valid && (emit.status == scbd_pkg::ST_VALID)) |-> (phase_r == scbd_pkg::PH_DATA))
    else $error("valid status produced outside the payload phase");

  // window end always returns to hunting with the packet state cleared
  a_window_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tlast) |=> ((phase_r == scbd_pkg::PH_HUNT1) && (bytes_seen_r == 8'd0) &&
                               (blocks_done_r == 6'd0)))
    else $error("parser not cleared after window end");

  // blocks and words are only reported with a valid status
  a_fields_zero_unless_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_valid && (emit.status != scbd_pkg::ST_VALID)) |->
      ((emit.block_count == 6'd0) && (emit.first_x == 16'd0) && (emit.first_y == 16'd0)))
    else $error("block fields set on a non-valid result");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the sync / checksum / block deframer
// ---------------------------------------------------------------------------
// Feeds read windows byte by byte and predicts every result inside the bench:
// sync hunt, header capture, payload sum, block count and the first block's
// X and Y words. A short table of hand-picked bytes comes first, then random
// windows under several register settings, with random gaps on both streams,
// one long sink hold-off and one extra full drain half-way through one setting.
// ---------------------------------------------------------------------------

module tb_top;
  import scbd_pkg::*;

  localparam int STALL_LIMIT      = 5000;  // cycles with no transfer at all
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int SETTINGS_COUNT   = 8;
  localparam int BYTES_PER_SET    = 150;
  localparam int HOLD_SET         = 7;     // setting with the long sink hold-off
  localparam int DRAIN_SET        = 2;     // setting with a mid-way drain
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // ------------------------------------------------------------------------
  // clock, reset and block ports; every input starts at a known value
  // ------------------------------------------------------------------------
  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [7:0]  cfg_data   = '0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  sync_checksum_block_deframer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ------------------------------------------------------------------------
  // deframer state as the bench sees it
  // ------------------------------------------------------------------------
  logic [7:0]  sync_first_reg  = SYNC_FIRST_RST;
  logic [7:0]  sync_second_reg = SYNC_SECOND_RST;
  logic [5:0]  block_bytes_reg = BLOCK_BYTES_RST;
  phase_t      parse_phase     = PH_HUNT1;
  logic [7:0]  hdr_length      = '0;
  logic [15:0] hdr_sum         = '0;
  logic [15:0] payload_sum     = '0;
  logic [7:0]  payload_count   = '0;
  logic [4:0]  block_pos       = '0;
  logic [5:0]  block_total     = '0;
  logic [15:0] x_acc           = '0;
  logic [15:0] y_acc           = '0;

  result_t     expected_results[$];
  result_t     last_prediction;
  int          predicted_total = 0;

  // bookkeeping
  int          fail_count    = 0;
  int          bytes_sent    = 0;
  int          windows_sent  = 0;
  int          status_seen[3] = '{0, 0, 0};
  int unsigned stalled_cycles = 0;

  // idling knobs, shared by the sender and the sink process
  int          src_idle_pct  = 30;
  int          sink_idle_pct = 30;
  bit          sink_hold_req = 1'b0;

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------
  task automatic clear_packet_state();
    hdr_length    = '0;
    hdr_sum       = '0;
    payload_sum   = '0;
    payload_count = '0;
    block_pos     = '0;
    block_total   = '0;
    x_acc         = '0;
    y_acc         = '0;
  endtask

  // block count and first-block words only go out with a valid status
  task automatic post_result(input status_t st, input logic [7:0] len);
    result_t r;
    bit      ok;
    ok               = (st == ST_VALID);
    r.status         = st;
    r.block_count    = ok ? block_total : 6'd0;
    r.first_x        = (ok && block_total != 0) ? x_acc : 16'd0;
    r.first_y        = (ok && block_total != 0) ? y_acc : 16'd0;
    r.payload_length = len;
    expected_results.push_back(r);
    last_prediction = r;
    predicted_total++;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic wend);
    int eff_block;
    int pos;
    bit produced;
    // out-of-range block sizes are clamped
    if (block_bytes_reg < BLOCK_BYTES_MIN)      eff_block = BLOCK_BYTES_MIN;
    else if (block_bytes_reg > BLOCK_BYTES_MAX) eff_block = BLOCK_BYTES_MAX;
    else                                        eff_block = block_bytes_reg;
    produced = 1'b0;

    case (parse_phase)
      PH_HUNT1: begin
        if (b == sync_first_reg) parse_phase = PH_HUNT2;
      end
      PH_HUNT2: begin
        // second sync wins over a repeated first sync byte
        if (b == sync_second_reg) begin
          clear_packet_state();
          parse_phase = PH_TYPE;
        end else if (b != sync_first_reg) begin
          parse_phase = PH_HUNT1;
        end
      end
      PH_TYPE: parse_phase = PH_LEN;
      PH_LEN: begin
        hdr_length  = b;
        parse_phase = PH_CKLO;
      end
      PH_CKLO: begin
        hdr_sum     = {8'h00, b};
        parse_phase = PH_CKHI;
      end
      PH_CKHI: begin
        hdr_sum[15:8] = b;
        if (hdr_length == 0) begin
          post_result(ST_INVALID, 8'd0);
          produced    = 1'b1;
          parse_phase = PH_DONE;
        end else begin
          parse_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        pos         = block_pos;
        payload_sum = payload_sum + b;
        // X word sits at bytes 2 and 3 of the first block, Y at 4 and 5
        if (block_total == 0) begin
          case (pos)
            2: x_acc[7:0]  = b;
            3: x_acc[15:8] = b;
            4: y_acc[7:0]  = b;
            5: y_acc[15:8] = b;
            default: ;
          endcase
        end
        if (pos + 1 >= eff_block) begin
          block_pos   = '0;
          block_total = block_total + 6'd1;
        end else begin
          block_pos = 5'(pos + 1);
        end
        payload_count = payload_count + 8'd1;
        if (payload_count == hdr_length) begin
          post_result((payload_sum == hdr_sum) ? ST_VALID : ST_INVALID, hdr_length);
          produced    = 1'b1;
          parse_phase = PH_DONE;
        end
      end
      default: ;
    endcase

    // window end inside a packet reports truncation, then back to hunting
    if (wend) begin
      if (!produced &&
          parse_phase inside {PH_TYPE, PH_LEN, PH_CKLO, PH_CKHI, PH_DATA}) begin
        post_result(ST_TRUNCATED,
                    (parse_phase inside {PH_CKLO, PH_CKHI, PH_DATA}) ? hdr_length : 8'd0);
      end
      parse_phase = PH_HUNT1;
      clear_packet_state();
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // ------------------------------------------------------------------------
  // monitor: all three handshakes sampled at the rising edge
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SYNC_FIRST:  sync_first_reg  = cfg_data;
          REG_SYNC_SECOND: sync_second_reg = cfg_data;
          REG_BLOCK_BYTES: block_bytes_reg = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) deframe_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: status %0d, tdata %h",
                 out_tuser, out_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          status_seen[int'(want.status)]++;
          check_field("status",         16'(want.status),         16'(out_tuser));
          check_field("block_count",    16'(want.block_count),    16'(out_tdata[5:0]));
          check_field("first_x",        want.first_x,             out_tdata[21:6]);
          check_field("first_y",        want.first_y,             out_tdata[37:22]);
          check_field("payload_length", 16'(want.payload_length), 16'(out_tdata[45:38]));
        end
      end
    end
  end

  // watchdog: ends a run that stops moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= STALL_LIMIT) begin
      $error("no transfer for %0d cycles, %0d results still pending",
             stalled_cycles, expected_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ------------------------------------------------------------------------
  // sink: random back-pressure, plus one long hold-off on request
  // ------------------------------------------------------------------------
  initial begin
    int sink_gap;
    sink_gap = 0;
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        out_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
        sink_hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (sink_gap > 0) begin
        out_tready <= 1'b0;
        sink_gap--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 99) < sink_idle_pct) sink_gap = pick_gap();
      end
    end
  end

  // ------------------------------------------------------------------------
  // sender side; every task starts and ends on a falling edge
  // ------------------------------------------------------------------------
  // valid stays high after the transfer so back-to-back bytes need no gap
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = ($urandom_range(0, 99) < src_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // stop offering bytes until every predicted result has been taken
  task automatic drain_results();
    in_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input int set_no);
    drain_results();
    // a trailing byte that made no result may still be in the parser
    repeat (4) @(negedge clk);
    case (set_no)
      1: begin
        write_reg(REG_SYNC_FIRST, 8'h00);
        write_reg(REG_SYNC_SECOND, 8'hFF);
        write_reg(REG_BLOCK_BYTES, 8'd6);
      end
      2: begin
        write_reg(REG_SYNC_FIRST, 8'hFF);
        write_reg(REG_SYNC_SECOND, 8'h00);
        write_reg(REG_BLOCK_BYTES, 8'd32);
      end
      3: begin
        // equal sync bytes, block size below range
        write_reg(REG_SYNC_FIRST, 8'h5A);
        write_reg(REG_SYNC_SECOND, 8'h5A);
        write_reg(REG_BLOCK_BYTES, 8'h00);
      end
      4: begin
        // all ones, masked to 63 and clamped to the top size
        write_reg(REG_SYNC_FIRST, 8'h3C);
        write_reg(REG_SYNC_SECOND, 8'hA5);
        write_reg(REG_BLOCK_BYTES, 8'hFF);
      end
      5: begin
        write_reg(REG_SYNC_FIRST, 8'h81);
        write_reg(REG_SYNC_SECOND, 8'h7E);
        write_reg(REG_BLOCK_BYTES, 8'd33);
        write_reg(REG_UNUSED, 8'hFF);
      end
      6: begin
        write_reg(REG_SYNC_FIRST, 8'($urandom_range(0, 255)));
        write_reg(REG_SYNC_SECOND, 8'($urandom_range(0, 255)));
        write_reg(REG_BLOCK_BYTES, 8'($urandom_range(0, 63)));
      end
      default: begin
        write_reg(REG_SYNC_FIRST, SYNC_FIRST_RST);
        write_reg(REG_SYNC_SECOND, SYNC_SECOND_RST);
        write_reg(REG_BLOCK_BYTES, 8'd11);
      end
    endcase
  endtask

  // one read window: mostly a well-formed packet with random content, some
  // noise-only windows, some cut short, some with a second packet behind
  task automatic send_window(input bit zero_len_only);
    logic [7:0]  win[$];
    logic [7:0]  body[$];
    logic [15:0] sum;
    int          kind, len, keep, r;
    kind = $urandom_range(0, 99);
    repeat ($urandom_range(0, 2)) win.push_back(8'($urandom_range(0, 255)));
    if (kind < 8 && !zero_len_only) begin
      repeat ($urandom_range(1, 8)) win.push_back(8'($urandom_range(0, 255)));
    end else begin
      r = $urandom_range(0, 99);
      if (zero_len_only || r < 10) len = 0;
      else if (r < 94)             len = $urandom_range(1, 70);
      else                         len = $urandom_range(150, 255);
      sum = '0;
      repeat (len) begin
        body.push_back(8'($urandom_range(0, 255)));
        sum = sum + body[$];
      end
      if ($urandom_range(0, 4) == 0) sum = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 9) == 0) win.push_back(sync_first_reg);
      win.push_back(sync_first_reg);
      win.push_back(sync_second_reg);
      win.push_back(8'($urandom_range(0, 255)));
      win.push_back(8'(len));
      win.push_back(sum[7:0]);
      win.push_back(sum[15:8]);
      foreach (body[i]) win.push_back(body[i]);
      if (kind < 25 && !zero_len_only) begin
        keep = $urandom_range(1, win.size());
        while (win.size() > keep) void'(win.pop_back());
      end else if (kind > 85) begin
        // a later packet in the same window must be ignored
        win.push_back(sync_first_reg);
        win.push_back(sync_second_reg);
        repeat ($urandom_range(1, 6)) win.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (win[i]) send_byte(win[i], i == win.size() - 1);
    windows_sent++;
  endtask

  // ------------------------------------------------------------------------
  // directed table: typed results are read straight off the spec
  // ------------------------------------------------------------------------
  typedef struct {
    logic [7:0] rx;
    logic       last;
    bit         typed;   // row carries a hand-written outcome
    bit         yields;  // that outcome is one result
    result_t    want;
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic result_t known_result(input status_t st, input int blocks,
                                           input int x, input int y, input int len);
    result_t r;
    r.status         = st;
    r.block_count    = 6'(blocks);
    r.first_x        = 16'(x);
    r.first_y        = 16'(y);
    r.payload_length = 8'(len);
    return r;
  endfunction

  task automatic add_row(input logic [7:0] rx, input logic last = 1'b0,
                         input bit typed = 1'b0, input bit yields = 1'b0,
                         input result_t want = '0);
    stim_row_t row;
    row.rx     = rx;
    row.last   = last;
    row.typed  = typed;
    row.yields = yields;
    row.want   = want;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed();
    // repeated first sync byte, then a zero-length packet
    add_row(SYNC_FIRST_RST);
    add_row(SYNC_FIRST_RST);
    add_row(SYNC_SECOND_RST);
    add_row(8'h00);
    add_row(8'h00);
    add_row(8'h34);
    add_row(8'h12, 1'b0, 1'b1, 1'b1, known_result(ST_INVALID, 0, 0, 0, 0));
    // a first sync byte after the packet is ignored up to window end
    add_row(SYNC_FIRST_RST);
    add_row(8'hFF, 1'b1, 1'b1, 1'b0);
    // window ends on the type byte, before any length was seen
    add_row(SYNC_FIRST_RST);
    add_row(SYNC_SECOND_RST);
    add_row(8'h5A, 1'b1, 1'b1, 1'b1, known_result(ST_TRUNCATED, 0, 0, 0, 0));
    // first sync byte on the last byte of a window
    add_row(SYNC_FIRST_RST, 1'b1, 1'b1, 1'b0);
    // two payload bytes, no complete block, done on the window's last byte
    add_row(SYNC_FIRST_RST);
    add_row(SYNC_SECOND_RST);
    add_row(8'hFF);
    add_row(8'h02);
    add_row(8'hFE);
    add_row(8'h01);
    add_row(8'hFF);
    add_row(8'hFF, 1'b1, 1'b1, 1'b1, known_result(ST_VALID, 0, 0, 0, 2));
    // largest length, cut inside the payload
    add_row(SYNC_FIRST_RST);
    add_row(SYNC_SECOND_RST);
    add_row(8'h00);
    add_row(8'hFF);
    add_row(8'h00);
    add_row(8'h00);
    add_row(8'h80, 1'b1, 1'b1, 1'b1, known_result(ST_TRUNCATED, 0, 0, 0, 255));
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    int prior_total;
    int set_start;
    int set_windows;
    bit drained;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    build_directed();
    foreach (directed_rows[i]) begin
      prior_total = predicted_total;
      send_byte(directed_rows[i].rx, directed_rows[i].last);
      if (directed_rows[i].typed) begin
        if ((predicted_total - prior_total) != int'(directed_rows[i].yields)) begin
          $error("directed byte %0d: expected %0d results, predicted %0d",
                 i, directed_rows[i].yields, predicted_total - prior_total);
          fail_count++;
        end else if (directed_rows[i].yields &&
                     last_prediction != directed_rows[i].want) begin
          $error("directed byte %0d: expected %h, predicted %h",
                 i, directed_rows[i].want, last_prediction);
          fail_count++;
        end
      end
    end

    for (int s = 0; s < SETTINGS_COUNT; s++) begin
      if (s > 0) apply_setting(s);
      if (s == HOLD_SET) begin
        // no idling here; the sink stalls long enough to fill the block
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        sink_hold_req = 1'b1;
      end else if (s % 2 == 1) begin
        src_idle_pct  = 10;
        sink_idle_pct = 50;
      end else begin
        src_idle_pct  = 30;
        sink_idle_pct = 30;
      end
      set_start   = bytes_sent;
      set_windows = 0;
      drained     = 1'b0;
      while (bytes_sent - set_start < BYTES_PER_SET) begin
        send_window(s == HOLD_SET && set_windows < 12);
        set_windows++;
        if (s == DRAIN_SET && !drained && bytes_sent - set_start >= BYTES_PER_SET / 2) begin
          drain_results();
          drained = 1'b1;
        end
      end
    end

    drain_results();
    repeat (10) @(posedge clk);

    $display("covered %0d bytes in %0d windows under %0d register settings",
             bytes_sent, windows_sent, SETTINGS_COUNT);
    $display("results checked: %0d valid, %0d invalid, %0d truncated",
             status_seen[0], status_seen[1], status_seen[2]);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
